FILE: sv/sbr_pkg.sv
// ----------------------------------------------------------------------------
// Stream byte reassembler package
// Shared types and constants for the reassembler front end, engine and queues.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam int INDEX_W = 64;
  localparam int BYTE_W  = 8;
  localparam int SPACE_W = 7;
  localparam int COUNT_W = 7;

  // One classified input transaction as it travels from front end to engine.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [INDEX_W-1:0] end_pos;
    logic [BYTE_W-1:0]  data;
    logic               has_byte;
    logic               ends;
    logic [SPACE_W-1:0] space;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               present;
    logic               last;
    logic               closed;
    logic [COUNT_W-1:0] pending;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_APPLY,
    BK_READ,
    BK_EMIT,
    BK_FINISH
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/sbr_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sbr_front.sv
// ----------------------------------------------------------------------------
// Reassembler front end
// Accepts input transactions, computes the end position and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_front
  import sbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [INDEX_W-1:0] in_stream_index,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               in_carries_byte,
  input  wire logic               in_ends_stream,
  input  wire logic [SPACE_W-1:0] in_space_free,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  wire logic               cmd_pop
);

  cmd_t cmd_in;
  logic cmd_empty;

  // The end position wraps modulo 2^64, as the stream position does.
  always_comb begin
    cmd_in.index    = in_stream_index;
    cmd_in.end_pos  = in_stream_index + INDEX_W'(in_carries_byte);
    cmd_in.data     = in_data_byte;
    cmd_in.has_byte = in_carries_byte;
    cmd_in.ends     = in_ends_stream;
    cmd_in.space    = in_space_free;
  end

  sbr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

FILE: sv/sbr_back.sv
// ----------------------------------------------------------------------------
// Reassembler engine
// Holds the window ring, stores bytes, trims the window and drains in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_back
  import sbr_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_push,
  output res_t      res
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int EXT_W = CNT_W + SPACE_W;

  back_state_t state_r, state_nxt;

  cmd_t                    cur_r, cur_nxt;
  logic [CNT_W-1:0]        cap_r, cap_nxt;
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]        base_r, base_nxt;
  logic [INDEX_W-1:0]      next_r, next_nxt;
  logic [CNT_W-1:0]        pend_r, pend_nxt;
  logic [CNT_W-1:0]        lim_r, lim_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic                    end_known_r, end_known_nxt;
  logic [INDEX_W-1:0]      end_pos_r, end_pos_nxt;
  logic                    closed_r, closed_nxt;
  logic [BYTE_W-1:0]       rdata_r;
  logic [BYTE_W-1:0]       win_mem_r [WINDOW_DEPTH];

  logic [EXT_W-1:0]   space_ext;
  logic [CNT_W-1:0]   cap_sat;
  logic               sweep_go;
  logic [IDX_W-1:0]   sweep_slot;
  logic [INDEX_W-1:0] delta;
  logic [CNT_W-1:0]   delta_lo;
  logic               in_win;
  logic [IDX_W-1:0]   store_slot;
  logic               store_ok;
  logic [IDX_W-1:0]   base_inc;
  logic               more;
  logic [CNT_W-1:0]   n_plus;
  logic [INDEX_W-1:0] next_inc;
  logic               emit_last;
  logic               emit_closed;
  logic               at_end;
  logic               close_only;
  logic [CNT_W-1:0]   pend_dec;
  logic [EXT_W-1:0]   pend_dec_ext;
  logic [EXT_W-1:0]   pend_ext;
  logic               mem_we;
  logic               mem_re;

  // Ring slot of a window offset; the sum stays below twice the depth.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] b,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(b) + SUM_W'(off);
    if (s >= SUM_W'(WINDOW_DEPTH)) begin
      s = s - SUM_W'(WINDOW_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign space_ext = EXT_W'(cmd.space);
  assign cap_sat   = (space_ext > EXT_W'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                         : CNT_W'(space_ext);

  // All valid slots lie at offsets below lim_r, so only [cap, lim) needs a trim.
  assign sweep_go   = (lim_r > cap_r);
  assign sweep_slot = slot_add(base_r, lim_r - 1'b1);

  assign delta      = cur_r.index - next_r;
  assign delta_lo   = delta[CNT_W-1:0];
  assign in_win     = cur_r.has_byte && (cur_r.index >= next_r) &&
                      (delta[INDEX_W-1:CNT_W] == '0) && (delta_lo < cap_r);
  assign store_slot = slot_add(base_r, delta_lo);
  assign store_ok   = in_win && !valid_r[store_slot];

  assign base_inc    = slot_add(base_r, CNT_W'(1));
  assign more        = (n_r < cap_r) && valid_r[base_r];
  assign n_plus      = n_r + 1'b1;
  assign next_inc    = next_r + 1'b1;
  assign emit_last   = !((n_plus < cap_r) && valid_r[base_inc]);
  assign emit_closed = end_known_r && (next_inc >= end_pos_r);
  assign at_end      = end_known_r && (next_r >= end_pos_r);
  assign close_only  = at_end && (n_r == '0);

  assign pend_dec     = pend_r - 1'b1;
  assign pend_dec_ext = EXT_W'(pend_dec);
  assign pend_ext     = EXT_W'(pend_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !closed_r) begin
          state_nxt = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (!sweep_go) begin
          state_nxt = BK_APPLY;
        end
      end
      BK_APPLY: state_nxt = BK_READ;
      BK_READ: begin
        state_nxt = more ? BK_EMIT : BK_FINISH;
      end
      BK_EMIT: begin
        if (!res_full) begin
          state_nxt = BK_READ;
        end
      end
      BK_FINISH: begin
        if (!(close_only && res_full)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Handshake outputs and result fields.
  always_comb begin
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    res.data    = rdata_r;
    res.present = 1'b1;
    res.last    = emit_last;
    res.closed  = emit_closed;
    res.pending = pend_dec_ext[COUNT_W-1:0];
    case (state_r)
      BK_IDLE:  cmd_pop = cmd_valid;
      BK_SWEEP: ;
      BK_APPLY: mem_we = store_ok;
      BK_READ:  mem_re = more;
      BK_EMIT:  res_push = !res_full;
      BK_FINISH: begin
        res_push    = close_only && !res_full;
        res.data    = '0;
        res.present = 1'b0;
        res.last    = 1'b1;
        res.closed  = 1'b1;
        res.pending = pend_ext[COUNT_W-1:0];
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    cur_nxt       = cur_r;
    cap_nxt       = cap_r;
    valid_nxt     = valid_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    pend_nxt      = pend_r;
    lim_nxt       = lim_r;
    n_nxt         = n_r;
    end_known_nxt = end_known_r;
    end_pos_nxt   = end_pos_r;
    closed_nxt    = closed_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          cap_nxt = cap_sat;
        end
      end
      BK_SWEEP: begin
        if (sweep_go) begin
          valid_nxt[sweep_slot] = 1'b0;
          if (valid_r[sweep_slot]) begin
            pend_nxt = pend_r - 1'b1;
          end
          lim_nxt = lim_r - 1'b1;
        end
      end
      BK_APPLY: begin
        if (store_ok) begin
          valid_nxt[store_slot] = 1'b1;
          pend_nxt              = pend_r + 1'b1;
        end
        if (in_win && (delta_lo >= lim_r)) begin
          lim_nxt = delta_lo + 1'b1;
        end
        if (cur_r.ends) begin
          end_known_nxt = 1'b1;
          end_pos_nxt   = cur_r.end_pos;
        end
        n_nxt = '0;
      end
      BK_READ: ;
      BK_EMIT: begin
        if (!res_full) begin
          valid_nxt[base_r] = 1'b0;
          base_nxt          = base_inc;
          next_nxt          = next_inc;
          pend_nxt          = pend_dec;
          n_nxt             = n_plus;
          lim_nxt           = lim_r - 1'b1;
        end
      end
      BK_FINISH: begin
        if (at_end) begin
          closed_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      base_r      <= '0;
      next_r      <= '0;
      pend_r      <= '0;
      lim_r       <= '0;
      n_r         <= '0;
      end_known_r <= 1'b0;
      end_pos_r   <= '0;
      closed_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      pend_r      <= pend_nxt;
      lim_r       <= lim_nxt;
      n_r         <= n_nxt;
      end_known_r <= end_known_nxt;
      end_pos_r   <= end_pos_nxt;
      closed_r    <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    cap_r <= cap_nxt;
  end

  // Window byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem_r[store_slot] <= cur_r.data;
    end
    if (mem_re) begin
      rdata_r <= win_mem_r[base_r];
    end
  end

endmodule

`default_nettype wire

FILE: sv/stream_byte_reassembler.sv
// Flow: the engine takes an accepted transaction from the command queue, trims the
//   slots that no longer fit when the free space shrinks, stores the byte, then reads
//   and emits each drained byte in order, stalling while the result queue is full.
// The engine takes no new transaction until it has finished with the last one.
// Reset: synchronous, active low; clears all slot valid bits, head, counts and end
//   state at once. No clearing pass; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// Stream byte reassembler
// Reorders stream bytes within a window ring and emits them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_byte_reassembler
  import sbr_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [INDEX_W-1:0] in_stream_index,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               in_carries_byte,
  input  wire logic               in_ends_stream,
  input  wire logic [SPACE_W-1:0] in_space_free,
  output logic                    empty,
  input  wire logic               pop,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    out_byte_present,
  output logic                    out_run_last,
  output logic                    out_stream_closed,
  output logic [COUNT_W-1:0]      out_pending_count
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  sbr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_stream_index (in_stream_index),
    .in_data_byte    (in_data_byte),
    .in_carries_byte (in_carries_byte),
    .in_ends_stream  (in_ends_stream),
    .in_space_free   (in_space_free),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  sbr_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  sbr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_byte          = res_out.data;
  assign out_byte_present  = res_out.present;
  assign out_run_last      = res_out.last;
  assign out_stream_closed = res_out.closed;
  assign out_pending_count = res_out.pending;

endmodule

`default_nettype wire

FILE: sim/stream_byte_reassembler_tb.sv
// ----------------------------------------------------------------------------
// Stream byte reassembler testbench
// Feeds out-of-order, duplicate, out-of-window and end-marker transactions to
// the reassembler under bursty input and a stalling receiver, and checks every
// emitted result against an in-bench model of the reorder window.
// ----------------------------------------------------------------------------

module stream_byte_reassembler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sbr_pkg::*;

  localparam int WIN         = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 130;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;
    logic               has_byte;
    logic               ends;
    logic [SPACE_W-1:0] space;
  } seg_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [INDEX_W-1:0] in_stream_index = '0;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               in_carries_byte = 1'b0;
  logic               in_ends_stream = 1'b0;
  logic [SPACE_W-1:0] in_space_free = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_byte_present;
  logic               out_run_last;
  logic               out_stream_closed;
  logic [COUNT_W-1:0] out_pending_count;

  // Stimulus and expectations.
  seg_item_t segment_q[$];
  res_t      emitted_q[$];
  seg_item_t drv_item;
  int        n_queued = 0;
  int        n_taken = 0;
  int        err_count = 0;
  int        cycle_count = 0;
  bit        taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  logic [15:0] pop_mask = '0;
  int        pop_phase = 0;

  // Model of the reorder window.
  logic [BYTE_W-1:0]  slot_data[WIN];
  bit                 slot_full[WIN];
  int                 ring_head = 0;
  logic [INDEX_W-1:0] rx_head = '0;
  int unsigned        held = 0;
  bit                 end_seen = 1'b0;
  logic [INDEX_W-1:0] end_at = '0;
  bit                 stream_done = 1'b0;

  always #1 clk = ~clk;

  stream_byte_reassembler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_stream_index  (in_stream_index),
    .in_data_byte     (in_data_byte),
    .in_carries_byte  (in_carries_byte),
    .in_ends_stream   (in_ends_stream),
    .in_space_free    (in_space_free),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_run_last     (out_run_last),
    .out_stream_closed(out_stream_closed),
    .out_pending_count(out_pending_count)
  );

  function automatic bit head_reached_end();
    return end_seen && (rx_head >= end_at);
  endfunction

  // Applies one accepted transaction to the window model and queues the
  // results it causes.
  function automatic void reassemble(input seg_item_t it);
    int unsigned        cap;
    int unsigned        n;
    int                 s;
    logic [INDEX_W-1:0] gap;
    res_t               r;
    res_t               prev;
    n = 0;
    prev = '0;
    if (stream_done) return;
    cap = (it.space > WIN) ? WIN : it.space;
    // A shrinking window throws away what no longer fits.
    for (int off = cap; off < WIN; off++) begin
      s = (ring_head + off) % WIN;
      if (slot_full[s]) begin
        slot_full[s] = 1'b0;
        if (held > 0) held--;
      end
    end
    if (it.has_byte && it.index >= rx_head) begin
      gap = it.index - rx_head;
      if (gap < 64'(cap)) begin
        s = (ring_head + int'(gap)) % WIN;
        if (!slot_full[s]) begin
          slot_data[s] = it.data;
          slot_full[s] = 1'b1;
          held++;
        end
      end
    end
    if (it.ends) begin
      end_seen = 1'b1;
      end_at = it.index + {63'd0, it.has_byte};
    end
    while (n < cap && slot_full[ring_head]) begin
      r.data = slot_data[ring_head];
      slot_full[ring_head] = 1'b0;
      ring_head = (ring_head + 1) % WIN;
      rx_head++;
      if (held > 0) held--;
      r.present = 1'b1;
      r.last = 1'b0;
      r.closed = head_reached_end();
      r.pending = held[COUNT_W-1:0];
      if (n > 0) emitted_q.push_back(prev);
      prev = r;
      n++;
    end
    if (head_reached_end()) begin
      stream_done = 1'b1;
      if (n == 0) begin
        prev = '0;
        prev.closed = 1'b1;
        prev.pending = held[COUNT_W-1:0];
        n = 1;
      end
    end
    if (n > 0) begin
      prev.last = 1'b1;
      emitted_q.push_back(prev);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  task automatic queue_item(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                            input logic has, input logic ends, input int unsigned space);
    seg_item_t it;
    it = '{idx, val, has, ends, space[SPACE_W-1:0]};
    segment_q.push_back(it);
    n_queued++;
  endtask

  // A run of consecutive stream bytes from the current head, sent in shuffled
  // order with occasional duplicates, tight windows and a far end marker.
  task automatic plan_run(input int unsigned len);
    int unsigned        order[$];
    int unsigned        j;
    int unsigned        tmp;
    int unsigned        sp;
    int unsigned        r;
    logic [INDEX_W-1:0] start;
    start = rx_head;
    for (int i = 0; i < len; i++) order.push_back(i);
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if ($urandom_range(0, 9) == 0)
      queue_item(start + 4096 + $urandom_range(0, 4095), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 64));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) sp = $urandom_range(0, order[i]);
      else if (r == 1) sp = $urandom_range(65, 127);
      else sp = $urandom_range(len, 64);
      queue_item(start + order[i], 8'($urandom_range(0, 255)), 1'b1, 1'b0, sp);
      if ($urandom_range(0, 5) == 0)
        queue_item(start + order[i] - $urandom_range(0, 2), 8'($urandom_range(0, 255)),
                   1'b1, 1'b0, 64);
    end
  endtask

  task automatic wait_accepted();
    while (n_taken != n_queued) @(posedge clk);
  endtask

  // Input driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || taken) begin
      taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (segment_q.size() > 0) begin
        drv_item = segment_q.pop_front();
        in_stream_index <= drv_item.index;
        in_data_byte <= drv_item.data;
        in_carries_byte <= drv_item.has_byte;
        in_ends_stream <= drv_item.ends;
        in_space_free <= drv_item.space;
        push <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: pop follows a 16-bit mask that is redrawn each time its phase wraps.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop_phase == 0) begin
        case ($urandom_range(0, 3))
          0: pop_mask = '1;
          1: pop_mask = 16'($urandom);
          2: pop_mask = 16'($urandom | $urandom);
          default: pop_mask = 16'($urandom & $urandom);
        endcase
      end
      pop <= pop_mask[pop_phase];
      pop_phase = (pop_phase + 1) % 16;
    end
  end

  // Monitor: model accepted input, compare accepted results.
  always @(posedge clk) begin
    seg_item_t acc;
    res_t      want;
    if (rst_n && push && !full) begin
      acc = '{in_stream_index, in_data_byte, in_carries_byte, in_ends_stream,
              in_space_free};
      reassemble(acc);
      taken = 1'b1;
      n_taken++;
    end
    if (rst_n && pop && !empty) begin
      if (emitted_q.size() == 0) begin
        $error("unexpected result transaction: out_byte %0h", out_byte);
        err_count++;
      end else begin
        want = emitted_q.pop_front();
        check_field("out_byte", 64'(out_byte), 64'(want.data));
        check_field("out_byte_present", 64'(out_byte_present), 64'(want.present));
        check_field("out_run_last", 64'(out_run_last), 64'(want.last));
        check_field("out_stream_closed", 64'(out_stream_closed), 64'(want.closed));
        check_field("out_pending_count", 64'(out_pending_count), 64'(want.pending));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned len;
    int unsigned k;
    bit          full_done;
    logic [INDEX_W-1:0] idx;
    rand_items = 0;
    full_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from an empty window at position zero.
    queue_item(64'd0, 8'h00, 1'b1, 1'b0, 0);            // no room downstream
    queue_item(64'd1, 8'hFF, 1'b1, 1'b0, 127);          // oversized free space
    queue_item(64'd63, 8'hA5, 1'b1, 1'b0, 64);          // last slot of the window
    queue_item(64'd64, 8'h5A, 1'b1, 1'b0, 64);          // just past the window
    queue_item(64'd0, 8'h3C, 1'b1, 1'b0, 64);           // fills the hole, drains two
    queue_item(64'd2, 8'h81, 1'b1, 1'b0, 1);            // shrink drops the far byte
    queue_item(64'd1, 8'h11, 1'b1, 1'b0, 64);           // behind the head
    queue_item(64'd5, 8'h22, 1'b1, 1'b0, 64);
    queue_item(64'd5, 8'h33, 1'b1, 1'b0, 64);           // already stored
    queue_item(64'd1000, 8'h00, 1'b0, 1'b1, 64);        // bare end marker
    queue_item(64'd2000, 8'h44, 1'b1, 1'b1, 64);        // end marker replaced
    queue_item(64'd4, 8'h55, 1'b1, 1'b0, 64);
    queue_item('1, 8'h66, 1'b1, 1'b0, 127);
    queue_item(64'h8000_0000_0000_0000, 8'h77, 1'b0, 1'b0, 0);
    queue_item(64'd6, 8'h88, 1'b1, 1'b0, 2);
    queue_item(64'd7, 8'h99, 1'b1, 1'b0, 64);

    while (rand_items < RAND_ITEMS) begin
      wait_accepted();
      if (!full_done && rand_items >= 50) begin
        // The whole window filled back to front, then drained in one go.
        for (int p = WIN - 1; p > 0; p--)
          queue_item(rx_head + p, 8'($urandom_range(0, 255)), 1'b1, 1'b0,
                     $urandom_range(64, 127));
        queue_item(rx_head, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 64);
        full_done = 1'b1;
        rand_items += WIN;
      end else if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
          idx = ($urandom_range(0, 3) == 0) ? rx_head + $urandom_range(0, 127)
                                           : {$urandom, $urandom};
          queue_item(idx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                     $urandom_range(0, 127));
        end
      end else begin
        len = $urandom_range(1, 12);
        plan_run(len);
        rand_items += len;
      end
    end

    // Close the stream, either through a wrapped end position that is already
    // behind the head or through the head byte that also ends the stream.
    wait_accepted();
    k = $urandom_range(1, 5);
    for (int i = 1; i <= k; i++)
      queue_item(rx_head + i, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 64);
    if ($urandom_range(0, 1) == 0)
      queue_item('1, 8'($urandom_range(0, 255)), 1'b1, 1'b1, $urandom_range(0, 127));
    else
      queue_item(rx_head, 8'($urandom_range(0, 255)), 1'b1, 1'b1, 64);

    // Once closed, everything is ignored.
    wait_accepted();
    for (int i = 0; i < 3; i++)
      queue_item(rx_head + i, 8'($urandom_range(0, 255)), 1'b1,
                 1'($urandom_range(0, 1)), 64);

    wait_accepted();
    while (emitted_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (err_count == 0 && emitted_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
